@@ rtl/gmcp_pkg.sv @@
// gmcp_pkg: shared widths, types, register indexes and helpers for the
// grid minimum-cost path unit. No dependencies.
package gmcp_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    localparam int COST_W = 16;
    localparam int SUM_W  = 27;
    localparam int DIM_W  = 11;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int IDX_W  = 1;

    typedef logic signed [COST_W-1:0] cost_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [DIM_W-1:0]         dim_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam idx_t REG_NUM_ROWS = idx_t'(0);
    localparam idx_t REG_NUM_COLS = idx_t'(1);

    typedef struct packed {
        logic has_up;
        logic has_left;
    } nbr_t;

    function automatic dim_t clamp_dim(input dim_t value, input dim_t max_value);
        dim_t result;
        if (value == '0)
        begin
            result = dim_t'(1);
        end
        else if (value > max_value)
        begin
            result = max_value;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

@@ rtl/gmcp_cell_calc.sv @@
// gmcp_cell_calc: path sum of one cell: cost plus the least existing
// neighbor sum, saturated to the sum width. Depends on gmcp_pkg.
module gmcp_cell_calc (
    input  gmcp_pkg::cost_t cost,
    input  gmcp_pkg::sum_t  up_sum,
    input  gmcp_pkg::sum_t  left_sum,
    input  gmcp_pkg::sum_t  upper_left_sum,
    input  gmcp_pkg::nbr_t  nbr,
    output gmcp_pkg::sum_t  path_sum
);
    import gmcp_pkg::*;

    sum_t                best;
    logic signed [SUM_W:0] total;

    always_comb
    begin
        best = '0;
        if (nbr.has_up)
        begin
            best = up_sum;
        end
        if (nbr.has_left && (!nbr.has_up || left_sum < best))
        begin
            best = left_sum;
        end
        if (nbr.has_up && nbr.has_left && upper_left_sum < best)
        begin
            best = upper_left_sum;
        end
        total = (SUM_W+1)'(cost) + (SUM_W+1)'(best);
        if (total[SUM_W] != total[SUM_W-1])
        begin
            path_sum = total[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            path_sum = total[SUM_W-1:0];
        end
    end

endmodule

@@ rtl/grid_min_cost_path_unit.sv @@
// grid_min_cost_path_unit: least-cost corner-to-corner path over a grid of
// cell costs taken in row-major order. Depends on gmcp_pkg, gmcp_cell_calc.
// Takes one cell word per cycle. Stage one reads the previous row's path sum
// from a one-port-read row buffer; stage two adds the cost to the least of the
// up, left and upper-left sums and writes it back. A single-column grid reads
// the entry being written and gets the new sum by forwarding. The result word
// goes to the output register when a grid's last cell leaves stage two. Input
// stalls only while a grid's last cell waits for a stalled, full output
// register. A write to either size register restarts the grid.
module grid_min_cost_path_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  gmcp_pkg::idx_t  cfg_index,
    input  gmcp_pkg::dim_t  cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  gmcp_pkg::cost_t cell_cost,
    output logic            out_valid,
    input  logic            out_stall,
    output gmcp_pkg::sum_t  min_cost
);
    import gmcp_pkg::*;

    localparam dim_t MAX_ROWS_DIM = dim_t'(MAX_ROWS);
    localparam dim_t MAX_COLS_DIM = dim_t'(MAX_COLS);

    sum_t row_mem [MAX_COLS];

    dim_t  rows_reg;
    dim_t  cols_reg;
    row_t  row_reg;
    col_t  col_reg;

    logic  s1_valid_reg;
    cost_t s1_cost_reg;
    nbr_t  s1_nbr_reg;
    logic  s1_last_reg;
    col_t  s1_col_reg;
    logic  s1_fwd_reg;
    sum_t  rdata_reg;

    sum_t  left_reg;
    sum_t  upper_left_reg;
    sum_t  last_val_reg;

    logic  out_valid_reg;
    sum_t  min_cost_reg;

    logic  accept;
    logic  s1_go;
    logic  out_free;
    logic  out_range;
    row_t  row_eff;
    col_t  col_eff;
    logic  row_end;
    logic  col_end;
    logic  is_last;
    row_t  row_next;
    col_t  col_next;
    sum_t  up_sum;
    sum_t  path_sum;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_go     = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign accept    = in_valid && !in_stall;

    assign out_range = (dim_t'(row_reg) >= rows_reg) || (dim_t'(col_reg) >= cols_reg);
    assign row_eff   = out_range ? '0 : row_reg;
    assign col_eff   = out_range ? '0 : col_reg;
    assign row_end   = (dim_t'(row_eff) + dim_t'(1)) >= rows_reg;
    assign col_end   = (dim_t'(col_eff) + dim_t'(1)) >= cols_reg;
    assign is_last   = row_end && col_end;

    always_comb
    begin
        row_next = row_eff;
        col_next = col_eff + col_t'(1);
        if (is_last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (col_end)
        begin
            row_next = row_eff + row_t'(1);
            col_next = '0;
        end
    end

    assign up_sum = s1_fwd_reg ? last_val_reg : rdata_reg;

    gmcp_cell_calc u_cell_calc (
        .cost           (s1_cost_reg),
        .up_sum         (up_sum),
        .left_sum       (left_reg),
        .upper_left_sum (upper_left_reg),
        .nbr            (s1_nbr_reg),
        .path_sum       (path_sum)
    );

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            row_mem[s1_col_reg] <= path_sum;
        end
        if (accept)
        begin
            rdata_reg <= row_mem[col_eff];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= dim_t'(1);
            cols_reg      <= dim_t'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_NUM_ROWS: rows_reg <= clamp_dim(cfg_data, MAX_ROWS_DIM);
                    REG_NUM_COLS: cols_reg <= clamp_dim(cfg_data, MAX_COLS_DIM);
                    default: ;
                endcase
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg         <= cell_cost;
            s1_nbr_reg.has_up   <= row_eff != '0;
            s1_nbr_reg.has_left <= col_eff != '0;
            s1_last_reg         <= is_last;
            s1_col_reg          <= col_eff;
            s1_fwd_reg          <= s1_go && (s1_col_reg == col_eff);
        end
        if (s1_go)
        begin
            left_reg       <= path_sum;
            upper_left_reg <= up_sum;
            last_val_reg   <= path_sum;
        end
        if (s1_go && s1_last_reg)
        begin
            min_cost_reg <= path_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_cost  = min_cost_reg;

`ifndef SYNTHESIS
    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_left_after_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write && !out_range && col_reg != '0) |=> s1_nbr_reg.has_left)
        else $error("left neighbor lost for a cell past the first column");

    a_forward_single_col: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg && s1_nbr_reg.has_up) |-> (cols_reg == dim_t'(1)))
        else $error("row buffer forwarding outside a single-column grid");

    a_result_from_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go && s1_last_reg))
        else $error("result word without a last cell");
`endif

endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for grid_min_cost_path_unit, covering small, odd and
// largest column-count grid sizes with random costs, gaps and output stalls.
// Depends on gmcp_pkg and grid_min_cost_path_unit.
module tb;

    import gmcp_pkg::*;

    localparam int  WATCHDOG_CYCLES = 1000;
    localparam int  ITEM_TARGET     = 1750;
    localparam int  SETTLE_CYCLES   = 8;
    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_write = 1'b0;
    idx_t   cfg_index = REG_NUM_ROWS;
    dim_t   cfg_data = '0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    cost_t  cell_cost = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    sum_t   min_cost;

    cost_t  cells_pending[$];
    sum_t   path_costs_due[$];

    longint col_path_sums[MAX_COLS];
    longint left_path;
    longint diag_path;
    int     grid_row;
    int     grid_col;
    int     rows_in_use;
    int     cols_in_use;

    int     in_gap = 0;
    int     out_gap = 0;
    int     in_idle_pct = 0;
    int     out_idle_pct = 0;
    bit     calm = 1'b0;
    int     quiet_cycles = 0;
    int     mismatch_count = 0;

    grid_min_cost_path_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .min_cost  (min_cost)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int size_in_use(input dim_t value, input int limit);
        int size;
        size = int'(value);
        if (size == 0)
        begin
            size = 1;
        end
        else if (size > limit)
        begin
            size = limit;
        end
        return size;
    endfunction

    task automatic restart_grid();
        grid_row = 0;
        grid_col = 0;
        left_path = 0;
        diag_path = 0;
    endtask

    task automatic apply_setting(input idx_t index, input dim_t value);
        if (index == REG_NUM_ROWS)
        begin
            rows_in_use = size_in_use(value, MAX_ROWS);
        end
        else
        begin
            cols_in_use = size_in_use(value, MAX_COLS);
        end
        restart_grid();
    endtask

    task automatic advance_grid(input cost_t cost);
        longint best;
        longint up_path;
        longint path;
        bit     has_up;
        bit     has_left;
        bit     have;
        int     r;
        int     c;
        r = grid_row;
        c = grid_col;
        if (r >= rows_in_use || c >= cols_in_use)
        begin
            restart_grid();
            r = 0;
            c = 0;
        end
        has_up = (r > 0);
        has_left = (c > 0);
        have = 1'b0;
        best = 0;
        up_path = col_path_sums[c];
        if (has_up)
        begin
            best = up_path;
            have = 1'b1;
        end
        if (has_left && (!have || left_path < best))
        begin
            best = left_path;
            have = 1'b1;
        end
        if (has_up && has_left && diag_path < best)
        begin
            best = diag_path;
        end
        path = longint'(cost) + best;
        if (path > SUM_HI)
        begin
            path = SUM_HI;
        end
        else if (path < SUM_LO)
        begin
            path = SUM_LO;
        end
        col_path_sums[c] = path;
        diag_path = up_path;
        left_path = path;
        if (r + 1 >= rows_in_use && c + 1 >= cols_in_use)
        begin
            restart_grid();
            path_costs_due.push_back(sum_t'(path));
        end
        else
        begin
            c++;
            if (c >= cols_in_use)
            begin
                c = 0;
                r++;
                left_path = 0;
                diag_path = 0;
            end
            grid_row = r;
            grid_col = c;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : cell_driver
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cell_cost <= '0;
            in_gap <= 0;
            rows_in_use = 1;
            cols_in_use = 1;
            restart_grid();
        end
        else
        begin
            if (cfg_write)
            begin
                apply_setting(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                advance_grid(cell_cost);
            end
            if (!in_valid || !in_stall)
            begin
                gap = in_gap;
                if (gap == 0 && !calm && $urandom_range(0, 99) < in_idle_pct)
                begin
                    gap = $urandom_range(1, 18);
                end
                if (gap != 0)
                begin
                    in_gap <= gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cells_pending.size() != 0)
                begin
                    in_valid <= 1'b1;
                    cell_cost <= cells_pending.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int   gap;
        sum_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (path_costs_due.size() == 0)
                begin
                    $error("min_cost: expected no word, got %0d", min_cost);
                    mismatch_count++;
                end
                else
                begin
                    want = path_costs_due.pop_front();
                    if (min_cost !== want)
                    begin
                        $error("min_cost: expected %0d, got %0d", want, min_cost);
                        mismatch_count++;
                    end
                end
            end
            gap = out_gap;
            if (gap != 0)
            begin
                gap--;
            end
            else if (!calm && $urandom_range(0, 99) < out_idle_pct)
            begin
                gap = $urandom_range(1, 18);
            end
            out_gap <= gap;
            out_stall <= (gap != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cost_t pick_cost();
        cost_t cost;
        case ($urandom_range(0, 9))
            0: cost = cost_t'(-32768);
            1: cost = cost_t'(32767);
            2: cost = cost_t'($signed($urandom_range(0, 16)) - 8);
            default: cost = cost_t'($urandom);
        endcase
        return cost;
    endfunction

    function automatic dim_t pick_dim();
        dim_t value;
        case ($urandom_range(0, 19))
            0: value = '0;
            1, 2: value = dim_t'($urandom_range(9, 24));
            default: value = dim_t'($urandom_range(1, 8));
        endcase
        return value;
    endfunction

    function automatic int pick_pct();
        int pct;
        case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 3;
            2: pct = 10;
            default: pct = 25;
        endcase
        return pct;
    endfunction

    task automatic write_reg(input idx_t index, input dim_t value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_sizes(input dim_t rows, input dim_t cols);
        write_reg(REG_NUM_ROWS, rows);
        write_reg(REG_NUM_COLS, cols);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (cells_pending.size() != 0 || in_valid || path_costs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            cells_pending.push_back(pick_cost());
        end
    endtask

    task automatic run_phases();
        int   single[5];
        int   corner[9];
        int   strip[3];
        int   column[4];
        dim_t rows;
        dim_t cols;
        int   cells;
        int   grids;
        int   queued_cells;
        single = '{-32768, 32767, 0, -1, 1};
        corner = '{1, 2, 3, 4, 8, 2, 1, 5, 3};
        strip = '{-5, 7, -32768};
        column = '{3, -3, 5, 5};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        in_idle_pct = 10;
        out_idle_pct = 10;
        foreach (single[i]) cells_pending.push_back(cost_t'(single[i]));
        wait_quiet();
        set_sizes(dim_t'(3), dim_t'(3));
        foreach (corner[i]) cells_pending.push_back(cost_t'(corner[i]));
        wait_quiet();
        set_sizes(dim_t'(0), dim_t'(3));
        foreach (strip[i]) cells_pending.push_back(cost_t'(strip[i]));
        wait_quiet();
        set_sizes(dim_t'(2), dim_t'(2));
        cells_pending.push_back(cost_t'(10));
        cells_pending.push_back(cost_t'(20));
        wait_quiet();
        set_sizes(dim_t'(4), dim_t'(1));
        foreach (column[i]) cells_pending.push_back(cost_t'(column[i]));
        wait_quiet();

        set_sizes(dim_t'(1), dim_t'(1025));
        queue_random(MAX_COLS);
        wait_quiet();

        queued_cells = $size(single) + $size(corner) + $size(strip) + 2 + $size(column)
                     + MAX_COLS;
        while (queued_cells < ITEM_TARGET)
        begin
            rows = pick_dim();
            cols = pick_dim();
            set_sizes(rows, cols);
            calm = (queued_cells >= ITEM_TARGET - 200);
            in_idle_pct = pick_pct();
            out_idle_pct = pick_pct();
            cells = size_in_use(rows, MAX_ROWS) * size_in_use(cols, MAX_COLS);
            grids = $urandom_range(1, 6);
            if (grids > 1 && cells * grids > ITEM_TARGET - queued_cells)
            begin
                grids = (ITEM_TARGET - queued_cells + cells - 1) / cells;
            end
            queue_random(cells * grids);
            queued_cells += cells * grids;
            if (cells > 1 && $urandom_range(0, 4) == 0)
            begin
                grids = $urandom_range(1, cells - 1);
                queue_random(grids);
                queued_cells += grids;
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        fork
            run_phases();
            wait (quiet_cycles >= WATCHDOG_CYCLES);
        join_any
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $error("no word moved for %0d cycles", quiet_cycles);
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
